@@ design/qsma_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsma_pkg
// Shared types and constants of the quadrature speed moving average block.
// ----------------------------------------------------------------------------
package qsma_pkg;

  localparam int COUNT_W  = 16;
  localparam int SAMPLE_W = 19;
  localparam int CFG_IDX_W = 1;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_A = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_B = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic edge_upd;   // apply pin edge flags to the counts
    logic tick_load;  // capture samples, read the slot, clear the counts
    logic sum_upd;    // write the slot, update sums and fill or head, start divide
    logic div_step;   // one quotient bit per channel
    logic avg_load;   // commit the new averages
    logic out_load;   // load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
  } status_t;

endpackage
`default_nettype wire

@@ design/qsma_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsma_if
// Request channels: encoder item input and averaged result output.
// ----------------------------------------------------------------------------
interface qsma_item_if;
  logic valid;
  logic ready;
  logic kind;
  logic flag_e1a;
  logic flag_e1b;
  logic flag_e2a;
  logic flag_e2b;
  logic level_e1a;
  logic level_e1b;
  logic level_e2a;
  logic level_e2b;

  modport source (
    output valid, kind, flag_e1a, flag_e1b, flag_e2a, flag_e2b,
           level_e1a, level_e1b, level_e2a, level_e2b,
    input  ready
  );
  modport sink (
    input  valid, kind, flag_e1a, flag_e1b, flag_e2a, flag_e2b,
           level_e1a, level_e1b, level_e2a, level_e2b,
    output ready
  );
endinterface

interface qsma_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qsma_pkg::SAMPLE_W-1:0] avg_a;
  logic signed [qsma_pkg::SAMPLE_W-1:0] avg_b;
  logic                                 window_empty;

  modport source (output valid, avg_a, avg_b, window_empty, input ready);
  modport sink   (input valid, avg_a, avg_b, window_empty, output ready);
endinterface
`default_nettype wire

@@ design/qsma_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsma_ctrl
// Sequencer for edge and tick requests and the result handshake.
// ----------------------------------------------------------------------------
module qsma_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  input  wire logic               item_kind,
  output logic                    item_ready,
  output logic                    result_valid,
  input  wire logic               result_ready,
  input  wire qsma_pkg::status_t  status,
  output qsma_pkg::cmd_t          cmd
);

  qsma_pkg::state_t state, state_next;
  logic             accept;
  logic             result_valid_next;

  assign item_ready = (state == qsma_pkg::ST_IDLE) && (!result_valid || result_ready);
  assign accept     = item_valid && item_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      qsma_pkg::ST_IDLE: begin
        if (accept && item_kind) state_next = qsma_pkg::ST_READ;
      end
      qsma_pkg::ST_READ:   state_next = qsma_pkg::ST_DIVIDE;
      qsma_pkg::ST_DIVIDE: begin
        if (status.div_last) state_next = qsma_pkg::ST_FINISH;
      end
      qsma_pkg::ST_FINISH: state_next = qsma_pkg::ST_IDLE;
      default:             state_next = qsma_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      qsma_pkg::ST_IDLE: begin
        if (accept) begin
          if (item_kind) begin
            cmd.tick_load = 1'b1;
          end else begin
            cmd.edge_upd = 1'b1;
            cmd.out_load = 1'b1;
          end
        end
      end
      qsma_pkg::ST_READ:   cmd.sum_upd = 1'b1;
      qsma_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
      qsma_pkg::ST_FINISH: begin
        cmd.avg_load = 1'b1;
        cmd.out_load = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    result_valid_next = result_valid;
    if (cmd.out_load)       result_valid_next = 1'b1;
    else if (result_ready)  result_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= qsma_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

`ifndef SYNTHESIS
  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!result_valid || result_ready))
    else $error("result overwritten while stalled");

  // a tick runs read, divide and finish before the next request
  a_tick_read: assert property (@(posedge clk) disable iff (rst)
    cmd.tick_load |=> (state == qsma_pkg::ST_READ) && !item_ready)
    else $error("tick did not enter read");

  a_div_finish: assert property (@(posedge clk) disable iff (rst)
    (state == qsma_pkg::ST_DIVIDE) && status.div_last |=> cmd.avg_load && cmd.out_load)
    else $error("divide did not finish");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.edge_upd, cmd.tick_load, cmd.sum_upd, cmd.div_step, cmd.avg_load}))
    else $error("conflicting datapath commands");
`endif

endmodule
`default_nettype wire

@@ design/qsma_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsma_dp
// Edge counters, sample window memory, running sums and restoring dividers.
// ----------------------------------------------------------------------------
module qsma_dp #(
  parameter int WINDOW_DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire qsma_pkg::cmd_t                       cmd,
  output qsma_pkg::status_t                         status,
  input  wire logic                                 cfg_we,
  input  wire logic [qsma_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic                                 cfg_data,
  input  wire logic                                 flag_e1a,
  input  wire logic                                 flag_e1b,
  input  wire logic                                 flag_e2a,
  input  wire logic                                 flag_e2b,
  input  wire logic                                 level_e1a,
  input  wire logic                                 level_e1b,
  input  wire logic                                 level_e2a,
  input  wire logic                                 level_e2b,
  output logic signed [qsma_pkg::SAMPLE_W-1:0]      res_avg_a,
  output logic signed [qsma_pkg::SAMPLE_W-1:0]      res_avg_b,
  output logic                                      res_empty
);

  localparam int SW     = qsma_pkg::SAMPLE_W;
  localparam int CW     = qsma_pkg::COUNT_W;
  localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = SW + $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(SUM_W + 1);
  localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(WINDOW_DEPTH);
  localparam logic [FILL_W:0]   DEPTH_P = (FILL_W + 1)'(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0]  LAST_I  = IDX_W'(WINDOW_DEPTH - 1);

  function automatic logic signed [CW-1:0] count_step(input logic signed [CW-1:0] c,
                                                      input logic up);
    if (up) return (c == qsma_pkg::COUNT_MAX) ? c : c + CW'(1);
    return (c == qsma_pkg::COUNT_MIN) ? c : c - CW'(1);
  endfunction

  function automatic logic signed [SW-1:0] make_sample(input logic signed [CW-1:0] c,
                                                       input logic inv);
    logic signed [SW-1:0] w;
    logic signed [SW-1:0] s;
    w = {{(SW - CW){c[CW-1]}}, c};
    s = (w <<< 2) + w;
    return inv ? -s : s;
  endfunction

  logic                    invert_a, invert_b;
  logic signed [CW-1:0]    count_a, count_b;
  logic [IDX_W-1:0]        head;
  logic [FILL_W-1:0]       fill;
  logic signed [SUM_W-1:0] sum_a, sum_b, sum_a_next, sum_b_next;
  logic signed [SW-1:0]    samp_a, samp_b;
  logic signed [SW-1:0]    avg_a, avg_b, avg_a_new, avg_b_new;
  logic [IDX_W-1:0]        slot, slot_q;
  logic [FILL_W:0]         pos;
  logic                    full, full_q;
  logic [2*SW-1:0]         mem [WINDOW_DEPTH];
  logic [2*SW-1:0]         rd_q;
  logic signed [SW-1:0]    old_a, old_b;
  logic [SUM_W-1:0]        num_a, num_b, num_a_next, num_b_next;
  logic [FILL_W-1:0]       rem_a, rem_b, rem_a_next, rem_b_next;
  logic                    neg_a, neg_b;
  logic [CNT_W-1:0]        cnt;
  logic [SUM_W-1:0]        q_a, q_b;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      invert_a <= 1'b1;
      invert_b <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qsma_pkg::CFG_INVERT_A: invert_a <= cfg_data;
        qsma_pkg::CFG_INVERT_B: invert_b <= cfg_data;
        default: ;
      endcase
    end
  end

  // edge counters; phase A flag wins over phase B
  always_ff @(posedge clk) begin
    if (rst) begin
      count_a <= '0;
      count_b <= '0;
    end else if (cmd.tick_load) begin
      count_a <= '0;
      count_b <= '0;
    end else if (cmd.edge_upd) begin
      if (flag_e1a)      count_a <= count_step(count_a, level_e1b);
      else if (flag_e1b) count_a <= count_step(count_a, !level_e1a);
      if (flag_e2a)      count_b <= count_step(count_b, level_e2b);
      else if (flag_e2b) count_b <= count_step(count_b, !level_e2a);
    end
  end

  // slot selection: append while filling, overwrite the oldest once full
  always_comb begin
    full = (fill == DEPTH_F);
    pos  = {1'b0, fill} + (FILL_W + 1)'(head);
    if (pos >= DEPTH_P) pos = pos - DEPTH_P;
    slot = full ? head : pos[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_load) begin
      samp_a <= make_sample(count_a, invert_a);
      samp_b <= make_sample(count_b, invert_b);
      slot_q <= slot;
      full_q <= full;
      rd_q   <= mem[slot];
    end
    if (cmd.sum_upd) mem[slot_q] <= {samp_a, samp_b};
  end

  assign old_a = rd_q[2*SW-1:SW];
  assign old_b = rd_q[SW-1:0];

  always_comb begin
    sum_a_next = sum_a + SUM_W'(samp_a) - (full_q ? SUM_W'(old_a) : '0);
    sum_b_next = sum_b + SUM_W'(samp_b) - (full_q ? SUM_W'(old_b) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_a <= '0;
      sum_b <= '0;
      fill  <= '0;
      head  <= '0;
    end else if (cmd.sum_upd) begin
      sum_a <= sum_a_next;
      sum_b <= sum_b_next;
      if (!full_q)              fill <= fill + 1'b1;
      else if (head == LAST_I)  head <= '0;
      else                      head <= head + 1'b1;
    end
  end

  // restoring division of |sum| by fill, one bit per cycle
  always_comb begin
    logic [FILL_W:0] sh_a, sh_b;
    logic            ge_a, ge_b;
    sh_a = {rem_a, num_a[SUM_W-1]};
    sh_b = {rem_b, num_b[SUM_W-1]};
    ge_a = sh_a >= {1'b0, fill};
    ge_b = sh_b >= {1'b0, fill};
    rem_a_next = ge_a ? FILL_W'(sh_a - {1'b0, fill}) : sh_a[FILL_W-1:0];
    rem_b_next = ge_b ? FILL_W'(sh_b - {1'b0, fill}) : sh_b[FILL_W-1:0];
    num_a_next = {num_a[SUM_W-2:0], ge_a};
    num_b_next = {num_b[SUM_W-2:0], ge_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.sum_upd) begin
      cnt <= CNT_W'(SUM_W);
    end else if (cmd.div_step) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_upd) begin
      neg_a <= sum_a_next[SUM_W-1];
      neg_b <= sum_b_next[SUM_W-1];
      num_a <= sum_a_next[SUM_W-1] ? -sum_a_next : sum_a_next;
      num_b <= sum_b_next[SUM_W-1] ? -sum_b_next : sum_b_next;
      rem_a <= '0;
      rem_b <= '0;
    end else if (cmd.div_step) begin
      num_a <= num_a_next;
      num_b <= num_b_next;
      rem_a <= rem_a_next;
      rem_b <= rem_b_next;
    end
  end

  assign status.div_last = (cnt == CNT_W'(1));

  always_comb begin
    q_a = neg_a ? -num_a : num_a;
    q_b = neg_b ? -num_b : num_b;
    avg_a_new = q_a[SW-1:0];
    avg_b_new = q_b[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_a <= '0;
      avg_b <= '0;
    end else if (cmd.avg_load) begin
      avg_a <= avg_a_new;
      avg_b <= avg_b_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_avg_a <= cmd.avg_load ? avg_a_new : avg_a;
      res_avg_b <= cmd.avg_load ? avg_b_new : avg_b;
      res_empty <= cmd.avg_load ? 1'b0 : (fill == '0);
    end
  end

endmodule
`default_nettype wire

@@ design/quadrature_speed_moving_average.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_speed_moving_average
// Two-channel quadrature edge counter with a sliding-window speed average.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready request channel. kind 0 carries pin edge flags and
//            levels, kind 1 is a sampling tick. Every request gives exactly
//            one result request on the result channel.
//   result : valid/ready; avg_a, avg_b and window_empty. A one-entry result
//            register holds the request until the receiver takes it.
//   cfg    : cfg_we/cfg_index/cfg_data write invert_a (index 0) and
//            invert_b (index 1); write only while the block is idle.
// Latency and throughput:
//   Edge request: result valid the cycle after acceptance; one edge request
//   per cycle sustained while the receiver keeps ready high.
//   Tick request: read, sum and finish steps with a restoring-divider step
//   per sum bit; the result is loaded in the finish step, and no new request
//   is taken before then.
// Reset (rst, synchronous): counts, sums, fill and head clear, averages read 0
//   with window_empty set, invert_a = 1, invert_b = 0. The window memory is
//   not cleared; only the values of written slots are ever used.
// Stall: while a result waits and the receiver holds ready low, item.ready
//   drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module quadrature_speed_moving_average #(
  parameter int WINDOW_DEPTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  qsma_item_if.sink                           item,
  qsma_result_if.source                       result,
  input  wire logic                           cfg_we,
  input  wire logic [qsma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic                           cfg_data
);

  // command and status between sequencer and datapath
  qsma_pkg::cmd_t    cmd;
  qsma_pkg::status_t status;

  // sequencer: request handshakes and tick steps
  qsma_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_kind    (item.kind),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  // datapath: counters, window memory, sums, divider and result register
  qsma_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .flag_e1a  (item.flag_e1a),
    .flag_e1b  (item.flag_e1b),
    .flag_e2a  (item.flag_e2a),
    .flag_e2b  (item.flag_e2b),
    .level_e1a (item.level_e1a),
    .level_e1b (item.level_e1b),
    .level_e2a (item.level_e2a),
    .level_e2b (item.level_e2b),
    .res_avg_a (result.avg_a),
    .res_avg_b (result.avg_b),
    .res_empty (result.window_empty)
  );

endmodule
`default_nettype wire
